// File: rtl/sfa_pkg.sv
`default_nettype none
package sfa_pkg;

	localparam int HEAP_BYTES = 1048576;
	localparam int NUM_CLASSES = 20;
	localparam int HEAP_WORDS = HEAP_BYTES / 4;
	localparam int WADDR_W = $clog2(HEAP_WORDS);
	localparam int BYTE_W = $clog2(HEAP_BYTES);
	localparam int HB_W = $clog2(HEAP_BYTES + 1);
	localparam int CLS_W = $clog2(NUM_CLASSES);
	localparam int WALK_LIMIT = HEAP_BYTES / 16;
	localparam int STEP_W = $clog2(WALK_LIMIT + 1);
	localparam int MIN_BLOCK = 16;
	localparam int CHUNK_RESET = 4096;
	localparam int CHUNK_W = 21;
	localparam int REQ_W = 21;
	localparam int INIT_BREAK = 16 + CHUNK_RESET;
	localparam int INIT_FTR_IDX = (16 + CHUNK_RESET - 8) / 4;
	localparam int INIT_EPI_IDX = (16 + CHUNK_RESET - 4) / 4;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE = 1'b1;
	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_FAIL = 1'b1;

	typedef enum logic [5:0] {
		S_CLEAR, S_IDLE, S_A0, S_F0, S_F1, S_F2, S_E0, S_E1,
		S_C0, S_C1, S_C2, S_C3, S_C4, S_C5, S_C6, S_C7,
		S_P0, S_P1, S_P2, S_P3, S_P4, S_FR0, S_FR1,
		S_LR0, S_LR1, S_LR2, S_LR3, S_LR4, S_LI0, S_LI1, S_LI2,
		S_ST0, S_ST1, S_DONE
	} state_t;

	function automatic logic [CLS_W-1:0] class_of(input logic [31:0] size);
		logic [CLS_W-1:0] c;
		c = '0;
		for (int i = 1; i < 32; i++) begin
			if (size[i]) begin
				c = (i > NUM_CLASSES - 1) ? CLS_W'(NUM_CLASSES - 1) : CLS_W'(i);
			end
		end
		return c;
	endfunction

	function automatic logic [31:0] init_word(input logic [WADDR_W-1:0] idx);
		logic [31:0] w;
		w = 32'd0;
		if (idx == WADDR_W'(1) || idx == WADDR_W'(2)) begin
			w = 32'd9;
		end else if (idx == WADDR_W'(3) || idx == WADDR_W'(INIT_FTR_IDX)) begin
			w = 32'(CHUNK_RESET);
		end else if (idx == WADDR_W'(INIT_EPI_IDX)) begin
			w = 32'd1;
		end
		return w;
	endfunction

endpackage
`default_nettype wire

// File: rtl/sfa_ram.sv
`default_nettype none
module sfa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// File: rtl/segregated_fit_allocator.sv
// Segregated-fit heap allocator with boundary tags over a 1 MiB word memory.
// Requests enter on the s_axis group: tuser selects allocate (0) or free (1),
// tdata carries the requested size and the block offset. Every request gives
// exactly one response on the m_axis group: tdata holds the payload offset of
// the allocated block (0 for a free or a failure), tuser the status.
// The controller makes at most one heap memory access in each state. A zero
// size or a rejected free ends without a walk; a free merges with each free
// neighbor; an allocation skips empty classes, walks past blocks that are too
// small, splits the block that it takes when the rest is large enough, and
// grows the heap, merging with a free block before the break, when none fits.
// The response becomes valid at the edge at which the next request can enter.
// One request is in work at a time; the response register lets the next
// request be accepted while the previous response is still waiting.
// After reset the block sweeps the heap memory once, writing the prologue,
// the first 4096-byte free chunk and the epilogue; requests are not accepted
// during the sweep. The user must write grow_chunk_bytes through
// cfg_we/cfg_wdata only while no request is in work; the block does not
// enforce it. When the receiver stalls, the response holds in the output
// register and no new work starts beyond the one request already taken.
`default_nettype none
module segregated_fit_allocator (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [sfa_pkg::CHUNK_W-1:0] cfg_wdata,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [47:0] s_axis_tdata,  // req_size[20:0], block_addr[40:21], zero pad
	input wire logic [0:0] s_axis_tuser,   // op
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [23:0] m_axis_tdata,      // result_addr[19:0], zero pad
	output logic [0:0] m_axis_tuser        // status
);
	import sfa_pkg::*;

	state_t state_q, state_d, ret_q;
	logic [WADDR_W-1:0] clr_q;
	logic [CHUNK_W-1:0] chunk_q;
	logic [HB_W-1:0] hb_q;
	logic [31:0] heads_q [NUM_CLASSES];
	logic op_q;
	logic [REQ_W-1:0] req_q;
	logic [BYTE_W-1:0] addr_q;
	logic [31:0] asize_q, bp_q, esize_q, cbp_q, csz_q, psize_q, nbp_q, pl_csize_q;
	logic pa_q, merge_q;
	logic [CLS_W-1:0] c_q, rm_cls_q, ins_cls_q;
	logic [STEP_W-1:0] steps_q;
	logic [31:0] rm_bp_q, rm_n_q, rm_p_q, ins_bp_q, ins_size_q, ins_h_q;
	logic [31:0] st_bp_q, st_size_q;
	logic st_a_q;
	logic [BYTE_W-1:0] res_addr_q;
	logic res_fail_q;
	logic out_v_q;
	logic [BYTE_W-1:0] out_addr_q;
	logic out_fail_q;

	logic mem_re, mem_we, rd_ok_q;
	logic [31:0] mem_raddr, mem_waddr, mem_wdata, ram_rdata, rdat;

	logic [31:0] hb32, ext, ewords, esize, ins_h;
	logic walk_end, fit, e_fail, fr0_bad, fr1_bad, nxt_used, out_free;
	logic [31:0] nh_size;

	assign hb32 = 32'(hb_q);
	assign rdat = rd_ok_q ? ram_rdata : 32'd0;
	assign walk_end = (bp_q == 32'd0) || (steps_q == STEP_W'(WALK_LIMIT));
	assign fit = asize_q <= (rdat & ~32'd7);
	assign ext = (asize_q > 32'(chunk_q)) ? asize_q : 32'(chunk_q);
	assign ewords = (ext >> 2) + {31'd0, ext[2]};
	assign esize = ewords << 2;
	assign e_fail = (hb32 + esize > 32'(HEAP_BYTES)) || (esize == 32'd0);
	assign fr0_bad = (addr_q[2:0] != 3'd0) || (32'(addr_q) < 32'd16) ||
		(32'(addr_q) >= hb32);
	assign fr1_bad = !rdat[0] || ((rdat & ~32'd7) < 32'(MIN_BLOCK)) ||
		(32'(addr_q) + (rdat & ~32'd7) > hb32);
	assign nh_size = rdat & ~32'd7;
	assign nxt_used = rdat[0] || (nbp_q >= hb32);
	assign ins_h = heads_q[class_of(ins_size_q)];
	assign out_free = !out_v_q || m_axis_tready;

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = {4'd0, out_addr_q};
	assign m_axis_tuser = out_fail_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (clr_q == '1) state_d = S_IDLE;
			S_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = (s_axis_tuser[0] == OP_FREE) ? S_FR0 : S_A0;
				end
			end
			S_A0: state_d = (req_q == '0) ? S_DONE : S_F0;
			S_F0: begin
				if (walk_end) begin
					state_d = (c_q == CLS_W'(NUM_CLASSES - 1)) ? S_E0 : S_F0;
				end else begin
					state_d = S_F1;
				end
			end
			S_F1: state_d = fit ? S_P0 : S_F2;
			S_F2: state_d = S_F0;
			S_E0: state_d = e_fail ? S_DONE : S_ST0;
			S_E1: state_d = S_C0;
			S_C0: state_d = S_C1;
			S_C1: state_d = S_C2;
			S_C2: state_d = S_C3;
			S_C3: state_d = nxt_used ? S_C4 : S_LR0;
			S_C4: state_d = pa_q ? S_C5 : S_LR0;
			S_C5: state_d = merge_q ? S_ST0 : S_C6;
			S_C6: state_d = S_LI0;
			S_C7: state_d = (op_q == OP_ALLOC) ? S_P0 : S_DONE;
			S_P0: state_d = S_P1;
			S_P1: state_d = S_LR0;
			S_P2: state_d = S_ST0;
			S_P3: state_d = S_ST0;
			S_P4: state_d = S_LI0;
			S_FR0: state_d = fr0_bad ? S_DONE : S_FR1;
			S_FR1: state_d = fr1_bad ? S_DONE : S_ST0;
			S_LR0: state_d = S_LR1;
			S_LR1: state_d = S_LR2;
			S_LR2: state_d = S_LR3;
			S_LR3: state_d = S_LR4;
			S_LR4: state_d = ret_q;
			S_LI0: state_d = S_LI1;
			S_LI1: state_d = S_LI2;
			S_LI2: state_d = ret_q;
			S_ST0: state_d = S_ST1;
			S_ST1: state_d = ret_q;
			S_DONE: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		mem_re = 1'b0;
		mem_raddr = 32'd0;
		mem_we = 1'b0;
		mem_waddr = 32'd0;
		mem_wdata = 32'd0;
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				mem_waddr = {12'd0, clr_q, 2'd0};
				mem_wdata = init_word(clr_q);
			end
			S_F0: begin
				mem_re = !walk_end;
				mem_raddr = bp_q - 32'd4;
			end
			S_F1: begin
				mem_re = !fit;
				mem_raddr = bp_q;
			end
			S_E1: begin
				mem_we = 1'b1;
				mem_waddr = bp_q + esize_q - 32'd4;
				mem_wdata = 32'd1;
			end
			S_C0: begin
				mem_re = 1'b1;
				mem_raddr = cbp_q - 32'd4;
			end
			S_C1: begin
				mem_re = 1'b1;
				mem_raddr = cbp_q - 32'd8;
			end
			S_C2: begin
				mem_re = 1'b1;
				mem_raddr = cbp_q + csz_q - 32'd4;
			end
			S_P0: begin
				mem_re = 1'b1;
				mem_raddr = bp_q - 32'd4;
			end
			S_FR0: begin
				mem_re = !fr0_bad;
				mem_raddr = 32'(addr_q) - 32'd4;
			end
			S_LR0: begin
				mem_re = 1'b1;
				mem_raddr = rm_bp_q - 32'd4;
			end
			S_LR1: begin
				mem_re = 1'b1;
				mem_raddr = rm_bp_q;
			end
			S_LR2: begin
				mem_re = 1'b1;
				mem_raddr = rm_bp_q + 32'd4;
			end
			S_LR3: begin
				mem_we = (rm_n_q != 32'd0);
				mem_waddr = rm_n_q + 32'd4;
				mem_wdata = rdat;
			end
			S_LR4: begin
				mem_we = (rm_p_q != 32'd0);
				mem_waddr = rm_p_q;
				mem_wdata = rm_n_q;
			end
			S_LI0: begin
				mem_we = 1'b1;
				mem_waddr = ins_bp_q;
				mem_wdata = ins_h;
			end
			S_LI1: begin
				mem_we = 1'b1;
				mem_waddr = ins_bp_q + 32'd4;
			end
			S_LI2: begin
				mem_we = (ins_h_q != 32'd0);
				mem_waddr = ins_h_q + 32'd4;
				mem_wdata = ins_bp_q;
			end
			S_ST0: begin
				mem_we = 1'b1;
				mem_waddr = st_bp_q - 32'd4;
				mem_wdata = st_size_q | {31'd0, st_a_q};
			end
			S_ST1: begin
				mem_we = 1'b1;
				mem_waddr = st_bp_q + st_size_q - 32'd8;
				mem_wdata = st_size_q | {31'd0, st_a_q};
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	sfa_ram #(
		.WIDTH(32),
		.DEPTH(HEAP_WORDS)
	) u_heap (
		.clk(clk),
		.we(mem_we && (mem_waddr[31:BYTE_W] == '0)),
		.waddr(mem_waddr[BYTE_W-1:2]),
		.wdata(mem_wdata),
		.re(mem_re && (mem_raddr[31:BYTE_W] == '0)),
		.raddr(mem_raddr[BYTE_W-1:2]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			ret_q <= S_IDLE;
			clr_q <= '0;
			chunk_q <= CHUNK_W'(CHUNK_RESET);
			hb_q <= HB_W'(INIT_BREAK);
			for (int i = 0; i < NUM_CLASSES; i++) begin
				heads_q[i] <= (i == int'(class_of(32'(CHUNK_RESET)))) ? 32'd16 : 32'd0;
			end
			rd_ok_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_ok_q <= mem_re && (mem_raddr[31:BYTE_W] == '0);
			if (cfg_we) begin
				chunk_q <= cfg_wdata;
			end
			if ((state_q == S_DONE) && out_free) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: clr_q <= clr_q + WADDR_W'(1);
				S_IDLE: begin
					op_q <= s_axis_tuser[0];
					req_q <= s_axis_tdata[REQ_W-1:0];
					addr_q <= s_axis_tdata[REQ_W+BYTE_W-1:REQ_W];
					res_addr_q <= '0;
					res_fail_q <= STATUS_FAIL;
				end
				S_A0: begin
					asize_q <= (req_q <= REQ_W'(8)) ? 32'd16 :
						((32'(req_q) + 32'd15) & ~32'd7);
					c_q <= class_of((req_q <= REQ_W'(8)) ? 32'd16 :
						((32'(req_q) + 32'd15) & ~32'd7));
					bp_q <= heads_q[class_of((req_q <= REQ_W'(8)) ? 32'd16 :
						((32'(req_q) + 32'd15) & ~32'd7))];
					steps_q <= '0;
				end
				S_F0: begin
					if (walk_end && (c_q != CLS_W'(NUM_CLASSES - 1))) begin
						c_q <= c_q + CLS_W'(1);
						bp_q <= heads_q[c_q + CLS_W'(1)];
						steps_q <= '0;
					end
				end
				S_F2: begin
					bp_q <= rdat;
					steps_q <= steps_q + STEP_W'(1);
				end
				S_E0: begin
					bp_q <= hb32;
					esize_q <= esize;
					st_bp_q <= hb32;
					st_size_q <= esize;
					st_a_q <= 1'b0;
					ret_q <= S_E1;
				end
				S_E1: begin
					hb_q <= HB_W'(hb32 + esize_q);
					cbp_q <= bp_q;
				end
				S_C1: begin
					csz_q <= rdat & ~32'd7;
					merge_q <= 1'b0;
				end
				S_C2: begin
					psize_q <= rdat & ~32'd7;
					pa_q <= rdat[0] || ((rdat & ~32'd7) == 32'd0) ||
						((rdat & ~32'd7) > cbp_q - 32'd16);
					nbp_q <= cbp_q + csz_q;
				end
				S_C3: begin
					if (!nxt_used) begin
						rm_bp_q <= nbp_q;
						csz_q <= csz_q + nh_size;
						merge_q <= 1'b1;
						ret_q <= S_C4;
					end
				end
				S_C4: begin
					if (!pa_q) begin
						rm_bp_q <= cbp_q - psize_q;
						cbp_q <= cbp_q - psize_q;
						csz_q <= csz_q + psize_q;
						merge_q <= 1'b1;
						ret_q <= S_C5;
					end
				end
				S_C5: begin
					st_bp_q <= cbp_q;
					st_size_q <= csz_q;
					st_a_q <= 1'b0;
					ret_q <= S_C6;
				end
				S_C6: begin
					ins_bp_q <= cbp_q;
					ins_size_q <= csz_q;
					ret_q <= S_C7;
				end
				S_C7: bp_q <= cbp_q;
				S_P0: begin
					res_addr_q <= bp_q[BYTE_W-1:0];
					res_fail_q <= STATUS_OK;
				end
				S_P1: begin
					pl_csize_q <= rdat & ~32'd7;
					rm_bp_q <= bp_q;
					ret_q <= S_P2;
				end
				S_P2: begin
					st_bp_q <= bp_q;
					st_a_q <= 1'b1;
					if ({1'b0, pl_csize_q} >= {1'b0, asize_q} + 33'd16) begin
						st_size_q <= asize_q;
						ret_q <= S_P3;
					end else begin
						st_size_q <= pl_csize_q;
						ret_q <= S_DONE;
					end
				end
				S_P3: begin
					st_bp_q <= bp_q + asize_q;
					st_size_q <= pl_csize_q - asize_q;
					st_a_q <= 1'b0;
					ret_q <= S_P4;
				end
				S_P4: begin
					ins_bp_q <= bp_q + asize_q;
					ins_size_q <= pl_csize_q - asize_q;
					ret_q <= S_DONE;
				end
				S_FR1: begin
					if (!fr1_bad) begin
						res_fail_q <= STATUS_OK;
						st_bp_q <= 32'(addr_q);
						st_size_q <= rdat & ~32'd7;
						st_a_q <= 1'b0;
						cbp_q <= 32'(addr_q);
						ret_q <= S_C0;
					end
				end
				S_LR1: rm_cls_q <= class_of(rdat & ~32'd7);
				S_LR2: rm_n_q <= rdat;
				S_LR3: rm_p_q <= rdat;
				S_LR4: begin
					if (rm_p_q == 32'd0) begin
						heads_q[rm_cls_q] <= rm_n_q;
					end
				end
				S_LI0: begin
					ins_h_q <= ins_h;
					ins_cls_q <= class_of(ins_size_q);
				end
				S_LI2: heads_q[ins_cls_q] <= ins_bp_q;
				S_DONE: begin
					if (out_free) begin
						out_addr_q <= res_addr_q;
						out_fail_q <= res_fail_q;
					end
				end
				default: begin
					clr_q <= clr_q;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

// File: bench/segregated_fit_allocator_tb.sv
`timescale 1ns / 1ps
module segregated_fit_allocator_tb;
	import sfa_pkg::*;

	typedef struct {
		logic [19:0] addr;
		logic status;
	} alloc_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CHUNK_W-1:0] cfg_wdata;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic [0:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [23:0] m_axis_tdata;
	logic [0:0] m_axis_tuser;

	int unsigned heap_mem [0:HEAP_WORDS-1];
	int unsigned class_head [0:NUM_CLASSES-1];
	int unsigned heap_brk;
	int unsigned chunk_bytes;

	alloc_result_t pending_results [$];
	int unsigned live_blocks [$];
	int mismatches;
	int sender_idle_pct;
	int receiver_idle_pct;
	int stall_budget;

	segregated_fit_allocator uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	function automatic int unsigned mem_rd(input int unsigned off);
		int unsigned idx;
		idx = off >> 2;
		return (idx < HEAP_WORDS) ? heap_mem[idx] : 0;
	endfunction

	function automatic void mem_wr(input int unsigned off, input int unsigned v);
		int unsigned idx;
		idx = off >> 2;
		if (idx < HEAP_WORDS) begin
			heap_mem[idx] = v;
		end
	endfunction

	function automatic int unsigned blk_sz(input int unsigned bp);
		return mem_rd(bp - 4) & ~32'd7;
	endfunction

	function automatic void put_tags(input int unsigned bp, input int unsigned sz,
			input int unsigned a);
		mem_wr(bp - 4, sz | a);
		mem_wr(bp + sz - 8, sz | a);
	endfunction

	function automatic int unsigned size_class(input int unsigned sz);
		int unsigned c;
		c = 0;
		while (c < NUM_CLASSES - 1 && sz > 1) begin
			sz = sz >> 1;
			c++;
		end
		return c;
	endfunction

	function automatic void list_push(input int unsigned bp, input int unsigned sz);
		int unsigned c;
		int unsigned h;
		c = size_class(sz);
		h = class_head[c];
		mem_wr(bp, h);
		mem_wr(bp + 4, 0);
		if (h != 0) begin
			mem_wr(h + 4, bp);
		end
		class_head[c] = bp;
	endfunction

	function automatic void list_unlink(input int unsigned bp);
		int unsigned c;
		int unsigned n;
		int unsigned p;
		c = size_class(blk_sz(bp));
		n = mem_rd(bp);
		p = mem_rd(bp + 4);
		if (n != 0) begin
			mem_wr(n + 4, p);
		end
		if (p != 0) begin
			mem_wr(p, n);
		end else begin
			class_head[c] = n;
		end
	endfunction

	function automatic int unsigned merge_free(input int unsigned bp);
		int unsigned sz;
		int unsigned pf;
		int unsigned psize;
		int unsigned nbp;
		int unsigned nh;
		bit prv_used;
		bit nxt_used;
		sz = blk_sz(bp);
		pf = mem_rd(bp - 8);
		psize = pf & ~32'd7;
		prv_used = (pf & 1) != 0 || psize == 0 || psize > bp - 16;
		nbp = bp + sz;
		nh = mem_rd(nbp - 4);
		nxt_used = (nh & 1) != 0 || nbp >= heap_brk;
		if (!nxt_used) begin
			list_unlink(nbp);
			sz += nh & ~32'd7;
		end
		if (!prv_used) begin
			list_unlink(bp - psize);
			sz += psize;
			bp -= psize;
		end
		if (!prv_used || !nxt_used) begin
			put_tags(bp, sz, 0);
		end
		list_push(bp, sz);
		return bp;
	endfunction

	function automatic int unsigned grow_heap(input int unsigned ext);
		int unsigned words;
		int unsigned sz;
		int unsigned bp;
		words = ext >> 2;
		if (words & 1) begin
			words++;
		end
		sz = words * 4;
		if (heap_brk + sz > HEAP_BYTES || sz == 0) begin
			return 0;
		end
		bp = heap_brk;
		put_tags(bp, sz, 0);
		mem_wr(bp + sz - 4, 1);
		heap_brk += sz;
		return merge_free(bp);
	endfunction

	function automatic int unsigned find_block(input int unsigned asize);
		int unsigned bp;
		int unsigned steps;
		for (int unsigned c = size_class(asize); c < NUM_CLASSES; c++) begin
			bp = class_head[c];
			steps = 0;
			while (bp != 0 && steps < WALK_LIMIT) begin
				if (asize <= blk_sz(bp)) begin
					return bp;
				end
				bp = mem_rd(bp);
				steps++;
			end
		end
		return 0;
	endfunction

	function automatic void carve(input int unsigned bp, input int unsigned asize);
		int unsigned csize;
		csize = blk_sz(bp);
		list_unlink(bp);
		if (csize >= asize + MIN_BLOCK) begin
			put_tags(bp, asize, 1);
			put_tags(bp + asize, csize - asize, 0);
			list_push(bp + asize, csize - asize);
		end else begin
			put_tags(bp, csize, 1);
		end
	endfunction

	function automatic void heap_init();
		for (int i = 0; i < HEAP_WORDS; i++) begin
			heap_mem[i] = 0;
		end
		for (int i = 0; i < NUM_CLASSES; i++) begin
			class_head[i] = 0;
		end
		chunk_bytes = CHUNK_RESET;
		heap_mem[1] = 9;
		heap_mem[2] = 9;
		heap_mem[3] = 1;
		heap_brk = 16;
		void'(grow_heap(chunk_bytes));
	endfunction

	function automatic alloc_result_t predict_request(input logic op, input int unsigned req,
			input int unsigned addr);
		alloc_result_t r;
		int unsigned asize;
		int unsigned bp;
		int unsigned h;
		int unsigned sz;
		r.addr = '0;
		r.status = STATUS_FAIL;
		if (op == OP_ALLOC) begin
			if (req == 0) begin
				return r;
			end
			asize = (req <= 8) ? 16 : 8 * ((req + 15) / 8);
			bp = find_block(asize);
			if (bp == 0) begin
				bp = grow_heap(asize > chunk_bytes ? asize : chunk_bytes);
				if (bp == 0) begin
					return r;
				end
			end
			carve(bp, asize);
			r.addr = bp[19:0];
			r.status = STATUS_OK;
		end else begin
			if ((addr & 7) != 0 || addr < 16 || addr >= heap_brk) begin
				return r;
			end
			h = mem_rd(addr - 4);
			sz = h & ~32'd7;
			if ((h & 1) == 0 || sz < MIN_BLOCK || addr + sz > heap_brk) begin
				return r;
			end
			put_tags(addr, sz, 0);
			void'(merge_free(addr));
			r.status = STATUS_OK;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		m_axis_tready = 0;
		forever begin
			@(posedge clk);
			if (stall_budget > 0) begin
				stall_budget--;
				m_axis_tready <= 0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		alloc_result_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("response with no request outstanding");
			end else begin
				e = pending_results.pop_front();
				if (m_axis_tdata[19:0] !== e.addr) begin
					report_mismatch($sformatf("result_addr %0h, expected %0h",
						m_axis_tdata[19:0], e.addr));
				end
				if (m_axis_tuser[0] !== e.status) begin
					report_mismatch($sformatf("status %0b, expected %0b",
						m_axis_tuser[0], e.status));
				end
			end
		end
	end

	task automatic send_request(input logic op, input int unsigned req, input int unsigned addr);
		alloc_result_t r;
		if ($urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
			while ($urandom_range(99) < sender_idle_pct) begin
				@(posedge clk);
			end
		end
		r = predict_request(op, req & 32'h1FFFFF, addr & 32'hFFFFF);
		pending_results.push_back(r);
		if (op == OP_ALLOC && r.status == STATUS_OK) begin
			live_blocks.push_back(r.addr);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= op;
		s_axis_tdata <= {7'd0, addr[19:0], req[20:0]};
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (64) @(posedge clk);
	endtask

	task automatic write_chunk(input int unsigned v);
		wait_drained();
		cfg_we <= 1;
		cfg_wdata <= v[CHUNK_W-1:0];
		@(posedge clk);
		cfg_we <= 0;
		chunk_bytes = v;
	endtask

	task automatic free_live(input int unsigned idx);
		int unsigned a;
		a = live_blocks[idx];
		live_blocks.delete(idx);
		send_request(OP_FREE, $urandom_range(2097151), a);
	endtask

	task automatic test_basic_alloc_free();
		send_request(OP_ALLOC, 0, 0);
		send_request(OP_ALLOC, 1, 20'hFFFFF);
		send_request(OP_ALLOC, 8, 0);
		send_request(OP_ALLOC, 9, 0);
		send_request(OP_ALLOC, 100, 0);
		send_request(OP_ALLOC, 5000, 0);
		send_request(OP_ALLOC, 2097151, 0);
		send_request(OP_ALLOC, 1048576, 0);
		free_live(1);
		free_live(1);
		free_live(0);
		send_request(OP_FREE, 0, 20'hFFFFF);
		send_request(OP_FREE, 0, 12);
		send_request(OP_FREE, 0, 21);
		send_request(OP_FREE, 0, 16);
		send_request(OP_FREE, 0, 4000);
	endtask

	task automatic test_chunk_settings();
		write_chunk(8);
		send_request(OP_ALLOC, 3000, 0);
		send_request(OP_ALLOC, 2000, 0);
		write_chunk(12);
		send_request(OP_ALLOC, 4000, 0);
		write_chunk(4100);
		send_request(OP_ALLOC, 3900, 0);
		write_chunk(1048576);
		send_request(OP_ALLOC, 8000, 0);
		send_request(OP_ALLOC, 16, 0);
		write_chunk(4096);
		while (live_blocks.size() > 0) begin
			free_live($urandom_range(live_blocks.size() - 1));
		end
		wait_drained();
	endtask

	task automatic random_item();
		int unsigned pick;
		int unsigned sz;
		pick = $urandom_range(99);
		if (pick < 72) begin
			if (live_blocks.size() > 0 && $urandom_range(99) < 47) begin
				free_live($urandom_range(live_blocks.size() - 1));
			end else begin
				sz = $urandom_range(99);
				if (sz < 75) begin
					sz = $urandom_range(1, 256);
				end else if (sz < 95) begin
					sz = $urandom_range(1, 8192);
				end else begin
					sz = $urandom_range(1, 65536);
				end
				send_request(OP_ALLOC, sz, $urandom_range(1048575));
			end
		end else if (pick < 78) begin
			send_request(OP_ALLOC, 0, $urandom_range(1048575));
		end else if (pick < 82) begin
			send_request(OP_ALLOC, $urandom_range(1048576, 2097151), 0);
		end else if (pick < 92) begin
			send_request(OP_FREE, $urandom_range(2097151), $urandom_range(1048575));
		end else if (live_blocks.size() > 0) begin
			send_request(OP_FREE, 0, live_blocks[$urandom_range(live_blocks.size() - 1)]
				+ 4 * $urandom_range(1, 3));
		end else begin
			send_request(OP_FREE, 0, heap_brk);
		end
	endtask

	task automatic test_random(input int n, input int s_idle, input int r_idle);
		wait_drained();
		sender_idle_pct = s_idle;
		receiver_idle_pct = r_idle;
		for (int i = 0; i < n; i++) begin
			random_item();
		end
	endtask

	task automatic test_backpressure();
		wait_drained();
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		stall_budget = 400;
		for (int i = 0; i < 25; i++) begin
			random_item();
		end
		wait_drained();
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = '0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		mismatches = 0;
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		stall_budget = 0;
		heap_init();
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_basic_alloc_free();
		test_chunk_settings();
		test_random(465, 32, 49);
		write_chunk(8);
		test_random(465, 49, 32);
		test_backpressure();
		write_chunk(65536);
		test_random(465, 0, 0);
		wait_drained();
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#50ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
